// ===== src/obrcv_pkg.sv =====
package obrcv_pkg;

    localparam int FRAC_BITS              = 31;
    localparam int DATA_W                 = 32;
    localparam int DEFAULT_MAX_HYPOTHESES = 1024;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_ERROR_LEVEL     = 2'd0;
    localparam logic [1:0] REG_ADAPT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GREEDY_MODE     = 2'd2;

    localparam logic [DATA_W-1:0] ERROR_LEVEL_RST     = 32'd107374182;
    localparam logic [DATA_W-1:0] ADAPT_THRESHOLD_RST = 32'd0;
    localparam logic              GREEDY_MODE_RST     = 1'b1;

    typedef enum logic [2:0] {
        CMD_LOAD_GAMMA = 3'd0,
        CMD_LOAD_PRIME = 3'd1,
        CMD_SUPPORT    = 3'd2,
        CMD_PVALUE     = 3'd3,
        CMD_START      = 3'd4
    } cmd_code_t;

    typedef struct packed {
        logic wr_gamma;
        logic wr_prime;
        logic support_upd;
        logic start_clr;
        logic latch_p;
        logic pv_do;
        logic pv_cap;
        logic base_mul1;
        logic base_mul2;
        logic base_add;
        logic greedy_add;
        logic mac_clear;
        logic mac_issue;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic cap_full;
        logic last_slot;
        logic out_free;
        logic mac_last;
        logic pipe_busy;
    } dp_status_t;

    function automatic logic [DATA_W-1:0] clamp_one(input logic [DATA_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE}) ? ONE : s[DATA_W-1:0];
    endfunction

endpackage

// ===== src/obrcv_ram.sv =====
module obrcv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/obrcv_ctrl.sv =====
module obrcv_ctrl
    import obrcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [2:0] command,
    input  logic       greedy_mode,
    input  dp_status_t status,
    output logic       item_stall,
    output dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PV     = 9'b000000010,
        ST_MUL1   = 9'b000000100,
        ST_MUL2   = 9'b000001000,
        ST_BADD   = 9'b000010000,
        ST_GREEDY = 9'b000100000,
        ST_MAC    = 9'b001000000,
        ST_DRAIN  = 9'b010000000,
        ST_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   is_start_reg, is_start_next;

    always_comb
    begin
        state_next    = state_reg;
        is_start_next = is_start_reg;
        cmd           = '0;
        item_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    case (cmd_code_t'(command))
                        CMD_LOAD_GAMMA: cmd.wr_gamma = 1'b1;
                        CMD_LOAD_PRIME: cmd.wr_prime = 1'b1;
                        CMD_SUPPORT:    cmd.support_upd = 1'b1;
                        CMD_START:
                        begin
                            cmd.start_clr = 1'b1;
                            is_start_next = 1'b1;
                            state_next    = ST_MUL1;
                        end
                        CMD_PVALUE:
                        begin
                            cmd.latch_p   = 1'b1;
                            is_start_next = 1'b0;
                            state_next    = ST_PV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PV:
            begin
                // wait for the output register, then commit the hypothesis
                if (status.out_free)
                begin
                    if (status.cap_full)
                    begin
                        cmd.pv_cap = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.pv_do  = 1'b1;
                        state_next = status.last_slot ? ST_IDLE : ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.base_mul1 = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.base_mul2 = 1'b1;
                state_next    = ST_BADD;
            end
            ST_BADD:
            begin
                cmd.base_add = 1'b1;
                if (is_start_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (greedy_mode)
                begin
                    state_next = ST_GREEDY;
                end
                else
                begin
                    cmd.mac_clear = 1'b1;
                    state_next    = ST_MAC;
                end
            end
            ST_GREEDY:
            begin
                cmd.greedy_add = 1'b1;
                state_next     = ST_FIN;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (status.mac_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            is_start_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            is_start_reg <= is_start_next;
        end
    end

endmodule

// ===== src/obrcv_dp.sv =====
module obrcv_dp
    import obrcv_pkg::*;
#(
    parameter int MAX_HYPOTHESES = DEFAULT_MAX_HYPOTHESES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dp_cmd_t                            cmd,
    output dp_status_t                         status,
    input  logic [9:0]                         table_index,
    input  logic [DATA_W-1:0]                  value,
    input  logic [DATA_W-1:0]                  error_level,
    input  logic [DATA_W-1:0]                  adapt_threshold,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [$clog2(MAX_HYPOTHESES+1)-1:0] hypothesis_number,
    output logic [DATA_W-1:0]                  critical_value,
    output logic                               rejected,
    output logic                               capacity_exceeded
);

    localparam int CW = $clog2(MAX_HYPOTHESES + 1);
    localparam int AW = $clog2(MAX_HYPOTHESES);
    localparam int PW = 2 * DATA_W;

    logic [CW-1:0]     cnt_reg, ovr_reg, mac_j_reg;
    logic [DATA_W-1:0] cv_reg, cb_reg, best_reg, p_reg;
    logic [DATA_W-1:0] acc_reg, prod1_reg, base_reg, reward_reg, prod_reg;
    logic              v1_reg, v2_reg;
    logic              out_v_reg;
    logic [CW-1:0]     num_reg;
    logic [DATA_W-1:0] ocv_reg;
    logic              rej_reg, cap_reg;

    logic [DATA_W-1:0] lam, sp_rdata, sm_rdata, rw_rdata, reward;
    logic              over, idx_ok;
    logic [CW-1:0]     ovr_next, sm_full;
    logic [AW-1:0]     sp_raddr;
    logic [PW-1:0]     mul1_full, mul2_full, mac_full;

    assign lam      = clamp_one(adapt_threshold);
    assign over     = p_reg > lam;
    assign reward   = over ? (cv_reg - best_reg) : '0;
    assign idx_ok   = 32'(table_index) < 32'(MAX_HYPOTHESES);
    assign ovr_next = ovr_reg + CW'(over);
    assign sp_raddr = cmd.pv_do ? ovr_next[AW-1:0] : '0;
    assign sm_full  = cnt_reg - CW'(1) - mac_j_reg;

    assign mul1_full = PW'(clamp_one(sp_rdata)) * PW'(clamp_one(error_level));
    assign mul2_full = PW'(prod1_reg) * PW'(ONE - lam);
    assign mac_full  = PW'(clamp_one(sm_rdata)) * PW'(rw_rdata);

    obrcv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_HYPOTHESES)) u_spend (
        .clk   (clk),
        .we    (cmd.wr_gamma && idx_ok),
        .waddr (AW'(table_index)),
        .wdata (value),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    obrcv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_HYPOTHESES)) u_smooth (
        .clk   (clk),
        .we    (cmd.wr_prime && idx_ok),
        .waddr (AW'(table_index)),
        .wdata (value),
        .raddr (sm_full[AW-1:0]),
        .rdata (sm_rdata)
    );

    obrcv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_HYPOTHESES)) u_reward (
        .clk   (clk),
        .we    (cmd.pv_do),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (reward),
        .raddr (mac_j_reg[AW-1:0]),
        .rdata (rw_rdata)
    );

    assign status.cap_full  = cnt_reg >= CW'(MAX_HYPOTHESES);
    assign status.last_slot = cnt_reg == CW'(MAX_HYPOTHESES - 1);
    assign status.out_free  = !out_v_reg || !result_stall;
    assign status.mac_last  = mac_j_reg == (cnt_reg - CW'(1));
    assign status.pipe_busy = v1_reg || v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ovr_reg   <= '0;
            cv_reg    <= '0;
            cb_reg    <= '0;
            best_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.pv_do || cmd.pv_cap)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_v_reg <= 1'b0;
            end
            if (cmd.support_upd && value <= cv_reg && value > best_reg)
            begin
                best_reg <= value;
            end
            if (cmd.start_clr)
            begin
                cnt_reg  <= '0;
                ovr_reg  <= '0;
                best_reg <= '0;
            end
            if (cmd.pv_do)
            begin
                cnt_reg  <= cnt_reg + CW'(1);
                ovr_reg  <= ovr_next;
                best_reg <= '0;
            end
            if (cmd.finish)
            begin
                cv_reg <= acc_reg;
                cb_reg <= base_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_p)
        begin
            p_reg <= value;
        end
        if (cmd.start_clr)
        begin
            acc_reg <= '0;
        end
        if (cmd.pv_do)
        begin
            reward_reg <= reward;
            acc_reg    <= over ? '0 : (cv_reg - cb_reg);
            num_reg    <= cnt_reg + CW'(1);
            ocv_reg    <= cv_reg;
            rej_reg    <= p_reg <= cv_reg;
            cap_reg    <= 1'b0;
        end
        if (cmd.pv_cap)
        begin
            num_reg <= '0;
            ocv_reg <= '0;
            rej_reg <= 1'b0;
            cap_reg <= 1'b1;
        end
        if (cmd.base_mul1)
        begin
            prod1_reg <= mul1_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
        if (cmd.base_mul2)
        begin
            base_reg <= mul2_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
        if (cmd.base_add)
        begin
            acc_reg <= sat_add(acc_reg, base_reg);
        end
        if (cmd.greedy_add)
        begin
            acc_reg <= sat_add(acc_reg, reward_reg);
        end
        if (cmd.mac_clear)
        begin
            mac_j_reg <= '0;
        end
        else if (cmd.mac_issue)
        begin
            mac_j_reg <= mac_j_reg + CW'(1);
        end
        if (v1_reg)
        begin
            prod_reg <= mac_full[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
        if (v2_reg)
        begin
            acc_reg <= sat_add(acc_reg, prod_reg);
        end
    end

    assign result_valid      = out_v_reg;
    assign hypothesis_number = num_reg;
    assign critical_value    = ocv_reg;
    assign rejected          = rej_reg;
    assign capacity_exceeded = cap_reg;

`ifndef NO_ASSERTIONS
    a_cv_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg <= ONE)
        else $error("critical value above one");
    a_base_le_cv: assert property (@(posedge clk) disable iff (!rst_n)
        cb_reg <= cv_reg)
        else $error("base above critical value");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_HYPOTHESES) && ovr_reg <= cnt_reg)
        else $error("hypothesis counters out of range");
    a_pipe_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !v1_reg && !v2_reg)
        else $error("critical value committed before accumulation drained");
`endif

endmodule

// ===== src/online_bonferroni_reward_critical_values.sv =====
// Results: a p-value gives a registered result, held until taken; table loads,
// support values and start commands give none.
// Input: loads and support values never stall the input side; start runs the base
// computation, and a p-value that leaves room in the tables runs it too, then the
// greedy step or the single multiply-accumulate; a stalled result holds the next p-value.
// Reset: asynchronous, active low; registers to their reset values, counters and cv zero.
module online_bonferroni_reward_critical_values
    import obrcv_pkg::*;
#(
    parameter int MAX_HYPOTHESES = DEFAULT_MAX_HYPOTHESES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [2:0]                         command,
    input  logic [9:0]                         table_index,
    input  logic [DATA_W-1:0]                  value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [$clog2(MAX_HYPOTHESES+1)-1:0] hypothesis_number,
    output logic [DATA_W-1:0]                  critical_value,
    output logic                               rejected,
    output logic                               capacity_exceeded,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [DATA_W-1:0] alpha_reg, lambda_reg;
    logic              greedy_reg;
    logic              cfg_wr;

    // Configuration registers: written on the access phase of an APB transfer.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ERROR_LEVEL_RST;
            lambda_reg <= ADAPT_THRESHOLD_RST;
            greedy_reg <= GREEDY_MODE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ERROR_LEVEL:     alpha_reg  <= pwdata;
                REG_ADAPT_THRESHOLD: lambda_reg <= pwdata;
                REG_GREEDY_MODE:     greedy_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ERROR_LEVEL:     prdata = alpha_reg;
            REG_ADAPT_THRESHOLD: prdata = lambda_reg;
            REG_GREEDY_MODE:     prdata = {31'd0, greedy_reg};
            default:             prdata = '0;
        endcase
    end

    // Sequencer: walks start commands, and p-values that leave table room, through
    // base computation and (p-values only) the reward step, stalling the input side meanwhile.
    obrcv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .command     (command),
        .greedy_mode (greedy_reg),
        .status      (status),
        .item_stall  (item_stall),
        .cmd         (cmd)
    );

    // Datapath: tables, reward history, multipliers and the output register,
    // which frees the input side while a result transfer waits.
    obrcv_dp #(.MAX_HYPOTHESES(MAX_HYPOTHESES)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .table_index       (table_index),
        .value             (value),
        .error_level       (alpha_reg),
        .adapt_threshold   (lambda_reg),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .hypothesis_number (hypothesis_number),
        .critical_value    (critical_value),
        .rejected          (rejected),
        .capacity_exceeded (capacity_exceeded)
    );

endmodule
